### src/bdf_pkg.sv
package bdf_pkg;

    // Widths of the byte stream and the result fields
    localparam int BYTE_W   = 8;
    localparam int SAMPLE_W = 24;
    localparam int GAIN_W   = 24;
    localparam int SCALED_W = 32;
    localparam int CHIDX_W  = 4;
    localparam int POS_W    = 6;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_MARKER = 2'd0,
        CFG_SCALE_GAIN   = 2'd1
    } cfg_reg_t;

    // Register reset values
    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hA0;
    localparam logic [GAIN_W-1:0] SCALE_GAIN_RST   = 24'h010000;

    // Parameter defaults
    localparam int NUM_CHANNELS_DEF   = 8;
    localparam int PACKET_BYTES_DEF   = 33;
    localparam int CHANNEL_OFFSET_DEF = 2;
    localparam int GAIN_FRAC_DEF      = 16;

endpackage

### src/biosignal_packet_deframer.sv
// Byte stream in: one byte per cycle, ready stays high except when a packet's
// last byte arrives while the previous packet's samples are still being read out.
// Results: once a packet's last byte is taken, its samples are read out one per cycle
// while out_ready allows (NUM_CHANNELS_P per packet), set by the one read port
// of the double-banked sample memory feeding a read / multiply / saturate pipeline.
// Reset: control state cleared, start_marker 0xA0, scale_gain 1.0; memory not cleared.
module biosignal_packet_deframer
    import bdf_pkg::*;
#(
    parameter int NUM_CHANNELS_P = NUM_CHANNELS_DEF,
    parameter int PACKET_BYTES   = PACKET_BYTES_DEF,
    parameter int CHANNEL_OFFSET = CHANNEL_OFFSET_DEF,
    parameter int GAIN_FRAC_BITS = GAIN_FRAC_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration writes
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    // byte stream
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [BYTE_W-1:0]          rx_byte,
    // sample results
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [CHIDX_W-1:0]         channel_index,
    output logic signed [SAMPLE_W-1:0] raw_sample,
    output logic signed [SCALED_W-1:0] scaled_sample,
    output logic                       last_of_packet
);

    localparam int CH_W     = (NUM_CHANNELS_P > 1) ? $clog2(NUM_CHANNELS_P) : 1;
    localparam int ADDR_W   = CH_W + 1;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;

    localparam logic [POS_W:0]  CH_START_C = (POS_W+1)'(CHANNEL_OFFSET);
    localparam logic [POS_W:0]  CH_END_C   = (POS_W+1)'(CHANNEL_OFFSET + 3*NUM_CHANNELS_P);
    localparam logic [POS_W:0]  LAST_POS_C = (POS_W+1)'(PACKET_BYTES - 1);
    localparam logic [CH_W-1:0] LAST_CH_C  = CH_W'(NUM_CHANNELS_P - 1);

    typedef enum logic {
        ST_HUNT,
        ST_COLLECT
    } state_t;

    // configuration registers
    logic [BYTE_W-1:0] start_marker_reg;
    logic [GAIN_W-1:0] scale_gain_reg;

    // framing state
    state_t              state_reg;
    logic [POS_W-1:0]    byte_pos_reg;
    logic [1:0]          phase_reg;
    logic [CH_W-1:0]     wr_ch_reg;
    logic                wr_bank_reg;
    logic [SAMPLE_W-1:0] asm_reg;
    logic [SAMPLE_W-1:0] asm_next;

    // readout sequencer
    logic            emit_active_reg;
    logic [CH_W-1:0] emit_ch_reg;
    logic            emit_bank_reg;

    // pipeline stage 1: memory read
    logic            s1_valid_reg;
    logic [CH_W-1:0] s1_ch_reg;
    logic            s1_last_reg;
    logic [SAMPLE_W-1:0] rd_data_reg;

    // pipeline stage 2: product
    logic                     s2_valid_reg;
    logic [CH_W-1:0]          s2_ch_reg;
    logic                     s2_last_reg;
    logic [SAMPLE_W-1:0]      s2_raw_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;

    // output stage
    logic                       out_valid_reg;
    logic [CHIDX_W-1:0]         out_ch_reg;
    logic                       out_last_reg;
    logic signed [SAMPLE_W-1:0] out_raw_reg;
    logic signed [SCALED_W-1:0] out_scaled_reg;

    logic [SAMPLE_W-1:0] mem [MEM_DEPTH];

    logic [POS_W:0]      pos_ext;
    logic                in_xfer;
    logic                is_last_byte;
    logic                in_ch_area;
    logic                mem_we;
    logic [ADDR_W-1:0]   wr_addr;
    logic [ADDR_W-1:0]   rd_addr;
    logic                s1_ready;
    logic                s2_ready;
    logic                s3_ready;
    logic                issue;
    logic                emit_done_now;
    logic                start_emit;
    logic signed [PROD_W-1:0]   prod_shr;
    logic signed [SCALED_W-1:0] scaled_sat;

    // byte decode
    assign pos_ext      = {1'b0, byte_pos_reg};
    assign is_last_byte = (state_reg == ST_COLLECT) && (pos_ext >= LAST_POS_C);
    assign in_ch_area   = (state_reg == ST_COLLECT) && (pos_ext >= CH_START_C)
                          && (pos_ext < CH_END_C);
    assign asm_next     = {asm_reg[SAMPLE_W-BYTE_W-1:0], rx_byte};

    // handshake: stall only the packet end while the previous burst is still issuing
    assign s3_ready      = !out_valid_reg || out_ready;
    assign s2_ready      = !s2_valid_reg || s3_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign issue         = emit_active_reg && s1_ready;
    assign emit_done_now = issue && (emit_ch_reg == LAST_CH_C);
    assign in_ready      = !(is_last_byte && emit_active_reg && !emit_done_now);
    assign in_xfer       = in_valid && in_ready;
    assign start_emit    = in_xfer && is_last_byte;

    assign mem_we  = in_xfer && in_ch_area && (phase_reg == 2'd2);
    assign wr_addr = {wr_bank_reg, wr_ch_reg};
    assign rd_addr = {emit_bank_reg, emit_ch_reg};

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_marker_reg <= START_MARKER_RST;
            scale_gain_reg   <= SCALE_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_START_MARKER: start_marker_reg <= cfg_data[BYTE_W-1:0];
                CFG_SCALE_GAIN:   scale_gain_reg   <= cfg_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // framing state machine and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_HUNT;
            byte_pos_reg <= '0;
            phase_reg    <= '0;
            wr_ch_reg    <= '0;
            wr_bank_reg  <= 1'b0;
        end
        else if (in_xfer)
        begin
            unique case (state_reg)
                ST_HUNT:
                begin
                    if (rx_byte == start_marker_reg)
                    begin
                        state_reg    <= ST_COLLECT;
                        byte_pos_reg <= POS_W'(1);
                        phase_reg    <= '0;
                        wr_ch_reg    <= '0;
                    end
                end
                ST_COLLECT:
                begin
                    if (in_ch_area)
                    begin
                        if (phase_reg == 2'd2)
                        begin
                            phase_reg <= '0;
                            wr_ch_reg <= wr_ch_reg + 1'b1;
                        end
                        else
                        begin
                            phase_reg <= phase_reg + 1'b1;
                        end
                    end
                    if (is_last_byte)
                    begin
                        state_reg    <= ST_HUNT;
                        byte_pos_reg <= '0;
                        wr_bank_reg  <= !wr_bank_reg;
                    end
                    else
                    begin
                        byte_pos_reg <= byte_pos_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= ST_HUNT;
                end
            endcase
        end
    end

    // sample assembly, big-endian three bytes
    always_ff @(posedge clk)
    begin
        if (in_xfer && in_ch_area)
        begin
            asm_reg <= asm_next;
        end
    end

    // sample memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= asm_next;
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // readout sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_active_reg <= 1'b0;
            emit_ch_reg     <= '0;
            emit_bank_reg   <= 1'b0;
        end
        else if (start_emit)
        begin
            emit_active_reg <= 1'b1;
            emit_ch_reg     <= '0;
            emit_bank_reg   <= wr_bank_reg;
        end
        else if (issue)
        begin
            if (emit_done_now)
            begin
                emit_active_reg <= 1'b0;
            end
            emit_ch_reg <= emit_ch_reg + 1'b1;
        end
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= issue;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_ch_reg   <= emit_ch_reg;
            s1_last_reg <= (emit_ch_reg == LAST_CH_C);
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_ch_reg   <= s1_ch_reg;
            s2_last_reg <= s1_last_reg;
            s2_raw_reg  <= rd_data_reg;
            s2_prod_reg <= $signed(rd_data_reg) * $signed({1'b0, scale_gain_reg});
        end
        if (s3_ready && s2_valid_reg)
        begin
            out_ch_reg     <= CHIDX_W'(s2_ch_reg);
            out_last_reg   <= s2_last_reg;
            out_raw_reg    <= $signed(s2_raw_reg);
            out_scaled_reg <= scaled_sat;
        end
    end

    // scale: arithmetic shift (floor), then saturate to 32 bits
    always_comb
    begin
        prod_shr = s2_prod_reg >>> GAIN_FRAC_BITS;
        if ((&prod_shr[PROD_W-1:SCALED_W-1]) || !(|prod_shr[PROD_W-1:SCALED_W-1]))
        begin
            scaled_sat = prod_shr[SCALED_W-1:0];
        end
        else
        begin
            scaled_sat = {prod_shr[PROD_W-1], {(SCALED_W-1){!prod_shr[PROD_W-1]}}};
        end
    end

    assign out_valid      = out_valid_reg;
    assign channel_index  = out_ch_reg;
    assign raw_sample     = out_raw_reg;
    assign scaled_sample  = out_scaled_reg;
    assign last_of_packet = out_last_reg;

endmodule
